>>> hdl/mm4_pkg.sv
// shared types and constants for the 4x4 fixed-point matrix multiplier
// no dependencies; imported by every module of the block
package mm4_pkg;

  localparam int ELEM_W    = 32;               // element width, signed fixed point
  localparam int FRAC_BITS = 16;               // fraction bits of an element
  localparam int DIM       = 4;                // matrix dimension
  localparam int DEPTH     = DIM * DIM;        // elements per matrix
  localparam int ADDR_W    = $clog2(DEPTH);    // element address width
  localparam int K_W       = $clog2(DIM);      // inner index width
  localparam int STEP_W    = ADDR_W + K_W;     // multiply-accumulate step count width
  localparam int PROD_W    = 2 * ELEM_W;       // exact product width
  localparam int ACC_W     = PROD_W + K_W;     // exact sum of DIM products

  // tag that travels down the pipeline beside the operands
  typedef struct packed {
    logic valid;      // stage holds a live step
    logic first;      // first term of a dot product
    logic last;       // last term of a dot product
    logic frame_end;  // last term of the last product element
  } tag_t;

endpackage

>>> hdl/mm4_store.sv
// element store: 16 x 32-bit memory, one write port, one registered read port
// depends on mm4_pkg
module mm4_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [mm4_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [mm4_pkg::ELEM_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [mm4_pkg::ADDR_W-1:0]  rd_addr,
  output logic [mm4_pkg::ELEM_W-1:0]  rd_data
);
  import mm4_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/mm4_mac.sv
// shared multiply-accumulate unit: registered 32x32 product, exact wide sum,
// floor truncation of the fraction and signed saturation; depends on mm4_pkg
module mm4_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  mm4_pkg::tag_t                      tag_in,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  a,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  b,
  output logic                               res_valid,
  output logic                               res_last,
  output logic        [mm4_pkg::ELEM_W-1:0]  res_value,
  output logic                               res_sat
);
  import mm4_pkg::*;

  localparam logic signed [ACC_W-1:0] V_MAX =
    {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] V_MIN =
    {{(ACC_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};

  tag_t                     mul_tag;
  logic signed [PROD_W-1:0] prod;
  logic                     acc_done;
  logic                     acc_end;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_tag  <= '0;
      acc_done <= 1'b0;
      acc_end  <= 1'b0;
    end else if (adv) begin
      mul_tag  <= tag_in;
      acc_done <= mul_tag.valid && mul_tag.last;
      acc_end  <= mul_tag.valid && mul_tag.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= PROD_W'(a) * PROD_W'(b);
      if (mul_tag.valid) begin
        if (mul_tag.first) begin
          acc <= ACC_W'(prod);
        end else begin
          acc <= acc + ACC_W'(prod);
        end
      end
    end
  end

  // arithmetic shift of the exact sum is a floor toward minus infinity
  assign shifted = acc >>> FRAC_BITS;

  always_comb begin
    if (shifted > V_MAX) begin
      res_value = V_MAX[ELEM_W-1:0];
      res_sat   = 1'b1;
    end else if (shifted < V_MIN) begin
      res_value = V_MIN[ELEM_W-1:0];
      res_sat   = 1'b1;
    end else begin
      res_value = shifted[ELEM_W-1:0];
      res_sat   = 1'b0;
    end
  end

  assign res_valid = acc_done;
  assign res_last  = acc_end;

endmodule

>>> hdl/matrix4_multiply_unit.sv
// top level of the 4x4 signed fixed-point matrix multiplier
// depends on mm4_pkg, mm4_store and mm4_mac
//
// usage:
//   s_axis carries one item per matrix position, row-major: tdata[31:0] is the
//   left element, tdata[63:32] the right element at the same position.
//   after the sixteenth item the block computes P = A * B on one shared
//   multiply-accumulate unit, four steps per product element, 64 steps per
//   matrix, and sends the sixteen elements of P on m_axis in row-major order.
//   tuser flags an element that was clamped, tlast marks the sixteenth.
// flow:
//   each step passes the memory read, the product register and the
//   accumulator; a finished element then enters the output register.
//   s_axis_tready is low while the sequencer issues the steps of a matrix,
//   and a stalled m_axis holds it low longer; loading of the next pair
//   overlaps the drain of the last results.
// reset: synchronous, active high; clears the load position, the sequencer
//   and the pipeline valid bits, so loading starts at element 0.
// stall: a stalled m_axis freezes the whole step pipeline (read, multiply,
//   accumulate) until the output register is taken; loads still proceed.
module matrix4_multiply_unit (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] left_element, [63:32] right_element
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] product_element
  output logic        m_axis_tuser,   // [0] saturated
  output logic        m_axis_tlast    // last_element
);
  import mm4_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_COMPUTE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] load_count;
  logic [STEP_W-1:0] step;          // {row, col, k} of the next step
  logic [ADDR_W-1:0] out_count;     // results sent in this matrix
  tag_t              rd_tag;        // tag beside the registered memory read

  logic              in_fire;
  logic              out_fire;
  logic              adv;           // pipeline advances this cycle
  logic              issue;
  logic [K_W-1:0]    k_idx;
  logic [K_W-1:0]    row;
  logic [K_W-1:0]    col;
  logic [ADDR_W-1:0] left_addr;
  logic [ADDR_W-1:0] right_addr;
  logic [ELEM_W-1:0] left_data;
  logic [ELEM_W-1:0] right_data;

  logic              res_valid;
  logic              res_last;
  logic [ELEM_W-1:0] res_value;
  logic              res_sat;

  assign s_axis_tready = (state == ST_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign issue         = (state == ST_COMPUTE);

  // step order: row-major product element, then inner index k
  assign k_idx      = step[K_W-1:0];
  assign col        = step[2*K_W-1:K_W];
  assign row        = step[STEP_W-1:2*K_W];
  assign left_addr  = {row, k_idx};   // A[row][k]
  assign right_addr = {k_idx, col};   // B[k][col]

  mm4_store u_left (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (load_count),
    .wr_data (s_axis_tdata[ELEM_W-1:0]),
    .rd_en   (adv),
    .rd_addr (left_addr),
    .rd_data (left_data)
  );

  mm4_store u_right (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (load_count),
    .wr_data (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
    .rd_en   (adv),
    .rd_addr (right_addr),
    .rd_data (right_data)
  );

  mm4_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tag_in    (rd_tag),
    .a         (left_data),
    .b         (right_data),
    .res_valid (res_valid),
    .res_last  (res_last),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

  // sequencer, load position, read tag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      load_count    <= '0;
      step          <= '0;
      out_count     <= '0;
      rd_tag        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            load_count <= load_count + 1'b1;
            if (load_count == ADDR_W'(DEPTH - 1)) begin
              state <= ST_COMPUTE;
              step  <= '0;
            end
          end
        end
        ST_COMPUTE: begin
          if (adv) begin
            step <= step + 1'b1;
            if (step == {STEP_W{1'b1}}) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase

      if (adv) begin
        rd_tag.valid     <= issue;
        rd_tag.first     <= (k_idx == '0);
        rd_tag.last      <= (k_idx == {K_W{1'b1}});
        rd_tag.frame_end <= (step == {STEP_W{1'b1}});
        m_axis_tvalid    <= res_valid;
      end

      if (out_fire) begin
        out_count <= out_count + 1'b1;
      end
    end
  end

  // output payload, loaded whenever the pipeline moves a finished element
  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= res_sat;
      m_axis_tlast <= res_last;
    end
  end

  // the sequencer only runs on a freshly wrapped load position
  a_compute_load_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPUTE) |-> (load_count == '0))
    else $error("step sequencer running with a partial load");

  // the end-of-matrix tag only rides on the last term of a dot product
  a_frame_end_on_last: assert property (@(posedge clk) disable iff (rst)
    (rd_tag.valid && rd_tag.frame_end) |-> rd_tag.last)
    else $error("frame end tag on an inner term");

  // tlast exactly on the sixteenth result of a matrix
  a_tlast_position: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (out_count == ADDR_W'(DEPTH - 1))))
    else $error("tlast out of place");

  // a clamped element carries one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000))
    else $error("saturated flag without a limit value");

endmodule
